// ===== hw/rtl/gld_pkg.sv =====
package gld_pkg;

  localparam int CODE_W            = 12;
  localparam int PIX_W             = 8;
  localparam int KIND_W            = 2;
  localparam int MCS_W             = 4;
  localparam int WIDTH_W           = 4;
  localparam int CMP_W             = 13;
  localparam int POW_W             = 16;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int MAX_CODE_BITS_DEF = 12;

  localparam int MCS_RESET         = 8;
  localparam int MCS_MIN           = 2;
  localparam int MCS_MAX           = 8;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CODE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PULL  = 2'd2;

  // pending string phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ROOT  = 2'd1;
  localparam logic [1:0] PH_CHAIN = 2'd2;
  localparam logic [1:0] PH_ROOT2 = 2'd3;

  typedef struct packed {
    logic                ent_we;
    logic [CODE_W-1:0]   ent_waddr;
    logic [CODE_W-1:0]   pfx_wdata;
    logic [PIX_W-1:0]    sfx_wdata;
    logic                fwd_we;
    logic [CODE_W-1:0]   fwd_waddr;
    logic [CODE_W-1:0]   fwd_wdata;
    logic [CODE_W-1:0]   rd_addr;
  } tbl_req_t;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel;
    logic                pixel_valid;
    logic                last_of_string;
    logic                code_accepted;
    logic [WIDTH_W-1:0]  code_width;
    logic                end_seen;
    logic                corrupt;
  } res_t;

  // clamp the minimum code size into its legal range
  function automatic logic [MCS_W-1:0] eff_size(input logic [MCS_W-1:0] m);
    logic [MCS_W-1:0] r;
    r = m;
    if (m < MCS_W'(MCS_MIN)) r = MCS_W'(MCS_MIN);
    if (m > MCS_W'(MCS_MAX)) r = MCS_W'(MCS_MAX);
    return r;
  endfunction

endpackage

// ===== hw/rtl/gld_ram.sv =====
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/gld_ctrl.sv =====
module gld_ctrl import gld_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [CODE_W-1:0]  code,
  input  logic [MCS_W-1:0]   min_code_size,
  input  logic [CODE_W-1:0]  pfx_rdata,
  input  logic [PIX_W-1:0]   sfx_rdata,
  input  logic [CODE_W-1:0]  fwd_rdata,
  output tbl_req_t           tbl_req,
  output res_t               res,
  output logic               res_valid,
  input  logic               res_ready
);

  localparam int TS_W = $clog2(TABLE_ENTRIES) + 1;
  localparam logic [CMP_W-1:0] TBL_END = CMP_W'(TABLE_ENTRIES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_PULL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state, state_next;
  logic [TS_W-1:0]    table_size;
  logic [WIDTH_W-1:0] width_now;
  logic [CODE_W-1:0]  prev_code;
  logic               expect_lit;
  logic [1:0]         out_phase;
  logic [CODE_W-1:0]  out_cursor;
  logic [PIX_W-1:0]   out_root;
  logic               repeat_root;
  logic               end_flag;
  logic               error_flag;

  logic [CODE_W-1:0]  cur;
  logic [CODE_W-1:0]  nxt;
  logic               walk_rep;
  logic [CODE_W-1:0]  code_q;
  logic [PIX_W-1:0]   r_pixel;
  logic               r_valid;
  logic               r_last;
  logic               r_acc;

  logic [MCS_W-1:0]   m_eff;
  logic [CODE_W-1:0]  clr, end_code, first_code;
  logic [TS_W-1:0]    ts_inc;
  logic               grow_width, can_add, cur_is_root, cur_out, fwd_end;
  logic               cursor_more, takeable, start_walk;
  logic [1:0]         phase_tail;

  assign m_eff      = eff_size(min_code_size);
  assign clr        = CODE_W'(1) << m_eff;
  assign end_code   = clr + CODE_W'(1);
  assign first_code = clr + CODE_W'(2);

  assign ts_inc      = table_size + TS_W'(1);
  assign grow_width  = (width_now < WIDTH_W'(MAX_CODE_BITS)) &&
                       (POW_W'(ts_inc) == (POW_W'(1) << width_now));
  assign can_add     = CMP_W'(table_size) < TBL_END;
  assign cur_is_root = cur < first_code;
  assign cur_out     = CMP_W'(cur) >= TBL_END;
  assign fwd_end     = (fwd_rdata == '0) || (CMP_W'(fwd_rdata) >= TBL_END);
  assign cursor_more = (out_cursor != '0) && (CMP_W'(out_cursor) < TBL_END);
  assign phase_tail  = repeat_root ? PH_ROOT2 : PH_IDLE;
  assign takeable    = (out_phase == PH_IDLE) && !end_flag && !error_flag;
  assign start_walk  = (kind == KIND_CODE) && takeable && (code != clr) &&
                       (code != end_code) && !expect_lit &&
                       (CMP_W'(code) <= CMP_W'(table_size));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (start_walk) state_next = S_WALK;
          else if (kind == KIND_PULL && out_phase == PH_CHAIN) state_next = S_PULL;
          else state_next = S_DONE;
        end
      end
      S_WALK: begin
        if (cur_is_root || cur_out) state_next = S_DONE;
        else state_next = S_WAIT;
      end
      S_WAIT: begin
        if (pfx_rdata >= nxt) state_next = S_DONE;
        else state_next = S_WALK;
      end
      S_PULL: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    tbl_req           = '0;
    tbl_req.ent_we    = (state == S_WALK) && cur_is_root && can_add;
    tbl_req.ent_waddr = CODE_W'(table_size);
    tbl_req.pfx_wdata = prev_code;
    tbl_req.sfx_wdata = cur[PIX_W-1:0];
    tbl_req.fwd_we    = (state == S_WALK) && !cur_is_root && !cur_out;
    tbl_req.fwd_waddr = cur;
    tbl_req.fwd_wdata = nxt;
    tbl_req.rd_addr   = (state == S_WALK) ? cur : out_cursor;
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.pixel          = r_pixel;
    res.pixel_valid    = r_valid;
    res.last_of_string = r_last;
    res.code_accepted  = r_acc;
    res.code_width     = width_now;
    res.end_seen       = end_flag;
    res.corrupt        = error_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      table_size  <= TS_W'((1 << MCS_RESET) + 2);
      width_now   <= WIDTH_W'(MCS_RESET + 1);
      prev_code   <= '0;
      expect_lit  <= 1'b0;
      out_phase   <= PH_IDLE;
      out_cursor  <= '0;
      out_root    <= '0;
      repeat_root <= 1'b0;
      end_flag    <= 1'b0;
      error_flag  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_pixel <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_acc   <= 1'b0;
            code_q  <= code;
            case (kind)
              KIND_START: begin
                table_size  <= TS_W'(first_code);
                width_now   <= m_eff + WIDTH_W'(1);
                prev_code   <= '0;
                expect_lit  <= 1'b0;
                out_phase   <= PH_IDLE;
                out_cursor  <= '0;
                out_root    <= '0;
                repeat_root <= 1'b0;
                end_flag    <= 1'b0;
                error_flag  <= 1'b0;
              end
              KIND_CODE: begin
                if (takeable) begin
                  r_acc <= 1'b1;
                  if (code == clr) begin
                    table_size <= TS_W'(first_code);
                    width_now  <= m_eff + WIDTH_W'(1);
                    expect_lit <= 1'b1;
                  end else if (code == end_code) begin
                    end_flag <= 1'b1;
                  end else if (expect_lit) begin
                    if (code >= clr) begin
                      error_flag <= 1'b1;
                    end else begin
                      out_root    <= code[PIX_W-1:0];
                      out_cursor  <= '0;
                      repeat_root <= 1'b0;
                      out_phase   <= PH_ROOT;
                      prev_code   <= code;
                      expect_lit  <= 1'b0;
                    end
                  end else if (CMP_W'(code) < CMP_W'(table_size)) begin
                    cur      <= code;
                    nxt      <= '0;
                    walk_rep <= 1'b0;
                  end else if (CMP_W'(code) == CMP_W'(table_size)) begin
                    cur      <= prev_code;
                    nxt      <= '0;
                    walk_rep <= 1'b1;
                  end else begin
                    error_flag <= 1'b1;
                  end
                end
              end
              KIND_PULL: begin
                case (out_phase)
                  PH_ROOT: begin
                    r_valid <= 1'b1;
                    r_pixel <= out_root;
                    if (cursor_more) begin
                      out_phase <= PH_CHAIN;
                    end else begin
                      out_phase <= phase_tail;
                      r_last    <= !repeat_root;
                    end
                  end
                  PH_ROOT2: begin
                    r_valid   <= 1'b1;
                    r_pixel   <= out_root;
                    r_last    <= 1'b1;
                    out_phase <= PH_IDLE;
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (cur_is_root) begin
            out_root    <= cur[PIX_W-1:0];
            out_cursor  <= nxt;
            repeat_root <= walk_rep;
            out_phase   <= PH_ROOT;
            prev_code   <= code_q;
            if (can_add) begin
              table_size <= ts_inc;
              if (grow_width) width_now <= width_now + WIDTH_W'(1);
            end
          end else if (cur_out) begin
            error_flag <= 1'b1;
            out_phase  <= PH_IDLE;
          end else begin
            nxt <= cur;
          end
        end
        S_WAIT: begin
          // a prefix must lie strictly below its own entry
          if (pfx_rdata >= nxt) begin
            error_flag <= 1'b1;
            out_phase  <= PH_IDLE;
          end else begin
            cur <= pfx_rdata;
          end
        end
        S_PULL: begin
          r_valid    <= 1'b1;
          r_pixel    <= sfx_rdata;
          out_cursor <= fwd_rdata;
          if (fwd_end) begin
            out_phase <= phase_tail;
            r_last    <= !repeat_root;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gif_lzw_code_decoder.sv =====
// GIF LZW code decoder. Feed it codes already unpacked from the bit stream
// (kind 1), start each image with kind 0 and pull palette indices one at a time
// with kind 2; every input word returns exactly one result word, which also
// reports the code width the unpacker must use next and the end and corrupt
// flags. A pull from the body of a string waits on the registered read of the
// suffix and forward-link memories; a table code walks its prefix chain back
// to the root, each step of the walk waiting on the registered read of the
// prefix memory. The block takes one word at a time, but the next word may be
// accepted while the previous result still waits in the output register. The
// three 4096-entry memories are not cleared after reset and need no clearing
// pass.
module gif_lzw_code_decoder import gld_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [MCS_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [CODE_W-1:0]  code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   pixel,
  output logic               pixel_valid,
  output logic               last_of_string,
  output logic               code_accepted,
  output logic [WIDTH_W-1:0] code_width,
  output logic               end_seen,
  output logic               corrupt
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic [MCS_W-1:0]  min_code_size;
  tbl_req_t          tbl_req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic [CODE_W-1:0] pfx_rdata;
  logic [PIX_W-1:0]  sfx_rdata;
  logic [CODE_W-1:0] fwd_rdata;

  // minimum code size register; the user must write it only while the decoder is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_size <= MCS_W'(MCS_RESET);
    end else if (cfg_we) begin
      min_code_size <= cfg_data;
    end
  end

  // sequencer: chain walk, dictionary growth and pixel pulls
  gld_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .code          (code),
    .min_code_size (min_code_size),
    .pfx_rdata     (pfx_rdata),
    .sfx_rdata     (sfx_rdata),
    .fwd_rdata     (fwd_rdata),
    .tbl_req       (tbl_req),
    .res           (res),
    .res_valid     (res_valid),
    .res_ready     (res_ready)
  );

  // dictionary: prefix and suffix of each entry, written together
  gld_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_ENTRIES)) u_prefix (
    .clk   (clk),
    .we    (tbl_req.ent_we),
    .waddr (tbl_req.ent_waddr[IDX_W-1:0]),
    .wdata (tbl_req.pfx_wdata),
    .raddr (tbl_req.rd_addr[IDX_W-1:0]),
    .rdata (pfx_rdata)
  );

  gld_ram #(.WIDTH(PIX_W), .DEPTH(TABLE_ENTRIES)) u_suffix (
    .clk   (clk),
    .we    (tbl_req.ent_we),
    .waddr (tbl_req.ent_waddr[IDX_W-1:0]),
    .wdata (tbl_req.sfx_wdata),
    .raddr (tbl_req.rd_addr[IDX_W-1:0]),
    .rdata (sfx_rdata)
  );

  // forward links, laid down during the walk so the string plays out root first
  gld_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_ENTRIES)) u_forward (
    .clk   (clk),
    .we    (tbl_req.fwd_we),
    .waddr (tbl_req.fwd_waddr[IDX_W-1:0]),
    .wdata (tbl_req.fwd_wdata),
    .raddr (tbl_req.rd_addr[IDX_W-1:0]),
    .rdata (fwd_rdata)
  );

  // output register: hold the result word until the consumer takes it
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      pixel          <= res.pixel;
      pixel_valid    <= res.pixel_valid;
      last_of_string <= res.last_of_string;
      code_accepted  <= res.code_accepted;
      code_width     <= res.code_width;
      end_seen       <= res.end_seen;
      corrupt        <= res.corrupt;
    end
  end

endmodule

// ===== hw/rtl/gld_checker.sv =====
module gld_checker import gld_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PIX_W-1:0]   pixel,
  input logic               pixel_valid,
  input logic               last_of_string,
  input logic               code_accepted,
  input logic [WIDTH_W-1:0] code_width
);

  localparam int MIN_WIDTH = MCS_MIN + 1;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(pixel_valid))
    else $error("result word changed while stalled");

  a_last_has_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_string |-> pixel_valid)
    else $error("end of string flagged without a pixel");

  a_code_no_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_accepted |-> !pixel_valid)
    else $error("code taken and pixel given in one word");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> code_width >= WIDTH_W'(MIN_WIDTH) &&
                  code_width <= WIDTH_W'(MAX_CODE_BITS))
    else $error("code width out of range");

endmodule

bind gif_lzw_code_decoder gld_checker #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_gld_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import gld_pkg::*;

  // kind 3 has no meaning to the block; it must come back as an empty word
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [MCS_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [KIND_W-1:0]  kind;
  logic [CODE_W-1:0]  code;
  logic               out_valid;
  logic               out_ready;
  logic [PIX_W-1:0]   pixel;
  logic               pixel_valid;
  logic               last_of_string;
  logic               code_accepted;
  logic [WIDTH_W-1:0] code_width;
  logic               end_seen;
  logic               corrupt;

  gif_lzw_code_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .code           (code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel          (pixel),
    .pixel_valid    (pixel_valid),
    .last_of_string (last_of_string),
    .code_accepted  (code_accepted),
    .code_width     (code_width),
    .end_seen       (end_seen),
    .corrupt        (corrupt)
  );

  // One directed stimulus row; typed rows carry a hand-written result word.
  typedef struct {
    logic [KIND_W-1:0] k;
    logic [CODE_W-1:0] c;
    bit                typed;
    res_t              want;
  } row_t;

  // Result words still owed by the block, oldest first
  res_t decoded_words[$];
  int   fails;
  int   words_checked;
  bit   calm;           // set for the closing stretch: no idling on either side

  // ---------------------------------------------------------------------------
  // Own copy of the decoder: dictionary, table growth and pending string
  // ---------------------------------------------------------------------------
  logic [MCS_W-1:0]   cfg_mcs;
  logic [CMP_W-1:0]   tsize;
  logic [WIDTH_W-1:0] width_cur;
  logic [CODE_W-1:0]  prev_cd;
  logic [CODE_W-1:0]  cursor;
  logic [PIX_W-1:0]   root_px;
  logic [1:0]         phase;
  bit                 want_lit;
  bit                 root_again;
  bit                 ended;
  bit                 broken;
  logic [CODE_W-1:0]  pfx_mem [TABLE_ENTRIES_DEF];
  logic [PIX_W-1:0]   sfx_mem [TABLE_ENTRIES_DEF];
  logic [CODE_W-1:0]  fwd_mem [TABLE_ENTRIES_DEF];

  // Sizes outside 2..8 behave as the nearest legal one
  function automatic logic [MCS_W-1:0] clamp_size(input logic [MCS_W-1:0] m);
    if (m < MCS_W'(MCS_MIN)) return MCS_W'(MCS_MIN);
    if (m > MCS_W'(MCS_MAX)) return MCS_W'(MCS_MAX);
    return m;
  endfunction

  function automatic logic [CMP_W-1:0] clear_of();
    return CMP_W'(1) << clamp_size(cfg_mcs);
  endfunction

  function automatic void restart_table();
    tsize     = clear_of() + CMP_W'(2);
    width_cur = clamp_size(cfg_mcs) + WIDTH_W'(1);
  endfunction

  function automatic void start_image();
    restart_table();
    prev_cd    = '0;
    want_lit   = 1'b0;
    phase      = PH_IDLE;
    cursor     = '0;
    root_px    = '0;
    root_again = 1'b0;
    ended      = 1'b0;
    broken     = 1'b0;
  endfunction

  function automatic void reset_model();
    cfg_mcs = MCS_W'(MCS_RESET);
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      pfx_mem[i] = '0;
      sfx_mem[i] = '0;
      fwd_mem[i] = '0;
    end
    start_image();
  endfunction

  // Walk back to the root, leaving forward links for the pixel pulls.
  // A prefix that does not lie below its entry means a broken chain.
  function automatic bit walk_chain(input logic [CODE_W-1:0] top, input bit again);
    logic [CMP_W-1:0] first;
    logic [CMP_W-1:0] cur;
    logic [CMP_W-1:0] nxt;
    first = clear_of() + CMP_W'(2);
    cur   = CMP_W'(top);
    nxt   = '0;
    while (cur >= first) begin
      if (cur >= CMP_W'(TABLE_ENTRIES_DEF)) return 1'b0;
      fwd_mem[cur[CODE_W-1:0]] = nxt[CODE_W-1:0];
      nxt = cur;
      cur = CMP_W'(pfx_mem[cur[CODE_W-1:0]]);
      if (cur >= nxt) return 1'b0;
    end
    root_px    = cur[PIX_W-1:0];
    cursor     = nxt[CODE_W-1:0];
    root_again = again;
    phase      = PH_ROOT;
    return 1'b1;
  endfunction

  // Grow the dictionary by one entry; stop growing once the table is full
  function automatic void add_entry();
    if (tsize >= CMP_W'(TABLE_ENTRIES_DEF)) return;
    pfx_mem[tsize[CODE_W-1:0]] = prev_cd;
    sfx_mem[tsize[CODE_W-1:0]] = root_px;
    tsize++;
    if (width_cur < WIDTH_W'(MAX_CODE_BITS_DEF) && tsize == (CMP_W'(1) << width_cur))
      width_cur++;
  endfunction

  function automatic void take_code(input logic [CODE_W-1:0] c);
    logic [CMP_W-1:0] clr;
    logic [CMP_W-1:0] cw;
    bit               ok;
    clr = clear_of();
    cw  = CMP_W'(c);
    if (cw == clr) begin
      restart_table();
      want_lit = 1'b1;
    end else if (cw == clr + CMP_W'(1)) begin
      ended = 1'b1;
    end else if (want_lit) begin
      // only a root may follow a clear
      if (cw >= clr) begin
        broken = 1'b1;
      end else begin
        root_px    = c[PIX_W-1:0];
        cursor     = '0;
        root_again = 1'b0;
        phase      = PH_ROOT;
        prev_cd    = c;
        want_lit   = 1'b0;
      end
    end else begin
      if (cw < tsize) begin
        ok = walk_chain(c, 1'b0);
      end else if (cw == tsize) begin
        // code not yet in the table: previous string plus its own first pixel
        ok = walk_chain(prev_cd, 1'b1);
      end else begin
        broken = 1'b1;
        return;
      end
      if (!ok) begin
        broken = 1'b1;
        phase  = PH_IDLE;
      end else begin
        add_entry();
        prev_cd = c;
      end
    end
  endfunction

  // Expected result word for one accepted input word
  function automatic res_t decode_word(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] c);
    res_t r;
    r = '0;
    case (k)
      KIND_START: start_image();
      KIND_CODE: begin
        if (phase == PH_IDLE && !ended && !broken) begin
          r.code_accepted = 1'b1;
          take_code(c);
        end
      end
      KIND_PULL: begin
        if (phase != PH_IDLE) begin
          r.pixel_valid = 1'b1;
          case (phase)
            PH_ROOT: begin
              r.pixel = root_px;
              if (cursor != '0) phase = PH_CHAIN;
              else if (root_again) phase = PH_ROOT2;
              else phase = PH_IDLE;
            end
            PH_CHAIN: begin
              r.pixel = sfx_mem[cursor];
              cursor  = fwd_mem[cursor];
              if (cursor == '0) phase = root_again ? PH_ROOT2 : PH_IDLE;
            end
            default: begin
              r.pixel = root_px;
              phase   = PH_IDLE;
            end
          endcase
          r.last_of_string = (phase == PH_IDLE);
        end
      end
      default: ;
    endcase
    r.code_width = width_cur;
    r.end_seen   = ended;
    r.corrupt    = broken;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Hand-written result at the reset code size, where the width is 9
  function automatic res_t res9(input logic [PIX_W-1:0] px, input bit pv, input bit last,
                                input bit acc, input bit e, input bit bad);
    res_t r;
    r.pixel          = px;
    r.pixel_valid    = pv;
    r.last_of_string = last;
    r.code_accepted  = acc;
    r.code_width     = WIDTH_W'(9);
    r.end_seen       = e;
    r.corrupt        = bad;
    return r;
  endfunction

  // Choose the next word from the decoder's present state: mostly well-formed
  // streams (pull every pending pixel, then a sensible code), plus some noise.
  function automatic void pick_word(input bit fill, output logic [KIND_W-1:0] k,
                                    output logic [CODE_W-1:0] c);
    int               r;
    logic [CMP_W-1:0] clr;
    logic [CMP_W-1:0] first;
    clr   = clear_of();
    first = clr + CMP_W'(2);
    r     = $urandom_range(0, 99);
    c     = CODE_W'($urandom);
    k     = KIND_CODE;
    if (phase != PH_IDLE) begin
      // a string is pending: drain it, now and then try a code or noise on it
      if (r < 88 || (fill && r < 95)) k = KIND_PULL;
      else if (r < 94 || fill) k = KIND_CODE;
      else if (r < 97) k = KIND_NONE;
      else k = KIND_START;
    end else if (ended || broken) begin
      if (r < 60) k = KIND_START;
      else if (r < 80) k = KIND_CODE;
      else if (r < 90) k = KIND_PULL;
      else k = KIND_NONE;
    end else if (fill) begin
      // roots keep the strings short while the table fills up
      if (r < 90 || tsize <= first) c = CODE_W'($urandom_range(0, int'(clr) - 1));
      else c = CODE_W'($urandom_range(int'(first), int'(tsize) - 1));
    end else if (want_lit) begin
      if (r < 82) c = CODE_W'($urandom_range(0, int'(clr) - 1));
      else if (r < 88) c = clr[CODE_W-1:0];
      else if (r < 92) c = CODE_W'(clr + CMP_W'(1));
      else if (r < 97) c = CODE_W'($urandom_range(int'(first), 4095));
      else k = KIND_PULL;
    end else begin
      if (r < 45 && tsize > first) c = CODE_W'($urandom_range(int'(first), int'(tsize) - 1));
      else if (r < 60 && tsize < CMP_W'(TABLE_ENTRIES_DEF)) c = tsize[CODE_W-1:0];
      else if (r < 78) c = CODE_W'($urandom_range(0, int'(clr) - 1));
      else if (r < 83) c = clr[CODE_W-1:0];
      else if (r < 86) c = CODE_W'(clr + CMP_W'(1));
      else if (r < 90 && tsize < CMP_W'(4095))
        c = CODE_W'($urandom_range(int'(tsize) + 1, 4095));
      else if (r < 95) k = KIND_PULL;
      else k = KIND_NONE;
    end
  endfunction

  // Offer one word, hold it until accepted, then log the word it must return
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] c,
                           input bit typed, input res_t typed_res);
    res_t r;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    code     <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = decode_word(k, c);
    decoded_words.push_back(typed ? typed_res : r);
  endtask

  // Drop valid and wait until every owed word is back, with a bound
  task automatic drain_results();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (decoded_words.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (decoded_words.size() != 0) begin
      $error("%0d result words never arrived", decoded_words.size());
      fails++;
      decoded_words.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // Write the code size while idle, start an image and run random words on it.
  // In fill mode keep going until the table is full and some codes beyond.
  task automatic run_phase(input logic [MCS_W-1:0] mcs, input int n_items, input bit fill);
    logic [KIND_W-1:0] k;
    logic [CODE_W-1:0] c;
    int                done;
    int                extra;
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mcs;
    cfg_mcs   = mcs;
    @(negedge clk);
    cfg_we   <= 1'b0;
    send_word(KIND_START, CODE_W'($urandom), 1'b0, '0);
    done  = 0;
    extra = 0;
    while (fill ? (extra < 40) : (done < n_items)) begin
      pick_word(fill, k, c);
      send_word(k, c, 1'b0, '0);
      done++;
      if (fill && tsize == CMP_W'(TABLE_ENTRIES_DEF) && k == KIND_CODE) extra++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, limit, sink and scoreboard
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit: many times the slowest legal run
  initial begin
    #50000000;
    $display("Regression FAIL");
    $finish;
  end

  // Sink: random stalls, plus one long hold-off to back the block up
  initial begin : sink
    bit choked;
    int n;
    choked    = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!choked && words_checked >= 60) begin
        choked     = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : score
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_words.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        want = decoded_words.pop_front();
        check_field("pixel", want.pixel, pixel);
        check_field("pixel_valid", want.pixel_valid, pixel_valid);
        check_field("last_of_string", want.last_of_string, last_of_string);
        check_field("code_accepted", want.code_accepted, code_accepted);
        check_field("code_width", want.code_width, code_width);
        check_field("end_seen", want.end_seen, end_seen);
        check_field("corrupt", want.corrupt, corrupt);
      end
      words_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stim
    row_t script [24];
    fails         = 0;
    words_checked = 0;
    calm          = 1'b0;
    reset_model();
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind     = KIND_START;
    code     = '0;

    // Reset code size is 8: clear 256, end 257, first table code 258
    script[0]  = '{KIND_PULL,  12'd0,    1'b1, res9(8'd0, 0, 0, 0, 0, 0)};  // nothing pending
    script[1]  = '{KIND_NONE,  12'd4095, 1'b1, res9(8'd0, 0, 0, 0, 0, 0)};  // unknown kind
    script[2]  = '{KIND_CODE,  12'd255,  1'b1, res9(8'd0, 0, 0, 1, 0, 0)};  // no clear first
    script[3]  = '{KIND_PULL,  12'd0,    1'b1, res9(8'd255, 1, 1, 0, 0, 0)};
    script[4]  = '{KIND_CODE,  12'd259,  1'b0, '0};                         // not yet in table
    script[5]  = '{KIND_CODE,  12'd0,    1'b1, res9(8'd0, 0, 0, 0, 0, 0)};  // string pending
    script[6]  = '{KIND_PULL,  12'd0,    1'b0, '0};
    script[7]  = '{KIND_PULL,  12'd0,    1'b0, '0};
    script[8]  = '{KIND_CODE,  12'd258,  1'b0, '0};                         // known table code
    script[9]  = '{KIND_PULL,  12'd0,    1'b0, '0};
    script[10] = '{KIND_PULL,  12'd0,    1'b0, '0};
    script[11] = '{KIND_CODE,  12'd256,  1'b1, res9(8'd0, 0, 0, 1, 0, 0)};  // clear
    script[12] = '{KIND_CODE,  12'd258,  1'b1, res9(8'd0, 0, 0, 1, 0, 1)};  // bad literal
    script[13] = '{KIND_CODE,  12'd0,    1'b1, res9(8'd0, 0, 0, 0, 0, 1)};  // locked by error
    script[14] = '{KIND_START, 12'd0,    1'b1, res9(8'd0, 0, 0, 0, 0, 0)};
    script[15] = '{KIND_CODE,  12'd256,  1'b1, res9(8'd0, 0, 0, 1, 0, 0)};
    script[16] = '{KIND_CODE,  12'd0,    1'b1, res9(8'd0, 0, 0, 1, 0, 0)};  // literal
    script[17] = '{KIND_PULL,  12'd0,    1'b1, res9(8'd0, 1, 1, 0, 0, 0)};
    script[18] = '{KIND_CODE,  12'd4095, 1'b1, res9(8'd0, 0, 0, 1, 0, 1)};  // above table
    script[19] = '{KIND_START, 12'd4095, 1'b1, res9(8'd0, 0, 0, 0, 0, 0)};
    script[20] = '{KIND_CODE,  12'd257,  1'b1, res9(8'd0, 0, 0, 1, 1, 0)};  // end code
    script[21] = '{KIND_CODE,  12'd1,    1'b1, res9(8'd0, 0, 0, 0, 1, 0)};  // locked by end
    script[22] = '{KIND_PULL,  12'd0,    1'b1, res9(8'd0, 0, 0, 0, 1, 0)};
    script[23] = '{KIND_START, 12'd0,    1'b1, res9(8'd0, 0, 0, 0, 0, 0)};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_word(script[i].k, script[i].c, script[i].typed, script[i].want);

    // Walk the code size through its range, out-of-range values included
    run_phase(4'd2, 90, 1'b0);
    run_phase(4'd0, 90, 1'b0);
    run_phase(4'd15, 90, 1'b0);
    run_phase(4'd3, 90, 1'b0);
    run_phase(4'd1, 90, 1'b0);
    run_phase(4'd8, 90, 1'b0);
    run_phase(4'd5, 90, 1'b0);
    // fill the dictionary to the top and keep decoding on a full table
    run_phase(4'd2, 0, 1'b1);
    run_phase(4'd9, 90, 1'b0);
    run_phase(4'd4, 90, 1'b0);
    run_phase(4'd7, 90, 1'b0);
    calm = 1'b1;
    run_phase(4'd6, 100, 1'b0);

    drain_results();
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== gif_lzw_code_decoder.f =====
hw/rtl/gld_pkg.sv
hw/rtl/gld_ram.sv
hw/rtl/gld_ctrl.sv
hw/rtl/gif_lzw_code_decoder.sv
hw/rtl/gld_checker.sv
sim/tb.sv
